### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: label");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: label");

// Next-cycle implication, also checked in reset.
`define ASSERT_NEXT_ALWAYS(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("assertion failed: label");

`endif

### hw/rtl/bma2d_pkg.sv
// Package for the 2D binned mean accumulator: sizes, codes, payload types.
// No dependencies.
`timescale 1ns / 1ps
package bma2d_pkg;
  localparam int MAX_X_BINS = 128;
  localparam int MAX_Y_BINS = 128;
  localparam int BIN_TOTAL  = MAX_X_BINS * MAX_Y_BINS;
  localparam int ADDR_W     = $clog2(BIN_TOTAL);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_COUNT  = 3'd5;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] sample_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [13:0]        bin_index;
    logic [15:0]        hit_count;
    logic signed [31:0] mean_value;
  } rsp_t;
endpackage

### hw/rtl/binned_mean_accumulator_2d_unit.sv
// Top level of the 2D binned mean accumulator: binning, bin store RMW, mean divider.
// Depends on bma2d_pkg.
`timescale 1ns / 1ps
// Steps from accept to result: coarse range check, 8 binning steps, index, memory read, RMW,
// 32 divide steps, result register. A point caught by the range check, or with a bin number
// past the count, goes straight to the result register; an empty bin skips the divide steps.
// Throughput: one request at a time, taken the cycle after the result is registered.
// The result register waits while out_stall holds the previous response.
// Reset: synchronous; a clearing pass zeroes all 16384 bins of the store, no request taken.
module binned_mean_accumulator_2d_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [bma2d_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bma2d_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  bma2d_pkg::req_t                    in_req,
  output logic                               out_valid,
  input  logic                               out_stall,
  output bma2d_pkg::rsp_t                    out_rsp
);
  import bma2d_pkg::*;

  localparam int QW = 8;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RANGE, S_BIN, S_INDEX, S_READ, S_MOD, S_DIV
  } state_t;
  // S_DIV also hosts result hand-off via div_done.

  state_t state;

  logic signed [31:0] x_origin, y_origin;
  logic [30:0]        x_step, y_step;
  logic [7:0]         x_count, y_count;

  logic [ADDR_W-1:0]  clr_addr;
  req_t               req;
  logic signed [32:0] dx, dy;
  logic [31:0]        rx, ry;
  logic [37:0]        divx, divy;
  logic [QW-1:0]      qx, qy;
  logic [2:0]         bit_cnt;
  logic [ADDR_W-1:0]  idx;
  logic [1:0]         status;
  logic [15:0]        cnt;
  logic [15:0]        rem;
  logic [31:0]        dq;
  logic               neg;
  logic [4:0]         div_cnt;
  logic               div_done;
  logic               out_load;

  logic [63:0]        mem [BIN_TOTAL];
  logic [63:0]        rdata;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [63:0]        mem_wdata;

  logic [7:0]         xc_eff, yc_eff;
  logic [15:0]        old_cnt;
  logic signed [47:0] old_sum, new_sum, fin_sum;
  logic [15:0]        fin_cnt;
  logic               sat;
  logic [47:0]        mag;
  logic [16:0]        shifted;
  logic               qbit;
  logic               bx, by;
  logic [31:0]        neg_q;

  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_DIV) && div_done && (!out_valid || !out_stall);

  assign xc_eff = (32'(x_count) > MAX_X_BINS) ? 8'(MAX_X_BINS) : x_count;
  assign yc_eff = (32'(y_count) > MAX_Y_BINS) ? 8'(MAX_Y_BINS) : y_count;

  assign bx = ({6'b0, rx} >= divx);
  assign by = ({6'b0, ry} >= divy);

  assign old_cnt = rdata[15:0];
  assign old_sum = rdata[63:16];
  assign new_sum = old_sum + {{16{req.sample_value[31]}}, req.sample_value};
  assign sat     = (req.req_type == REQ_INSERT) && (old_cnt == 16'hFFFF);
  always_comb begin
    if (req.req_type == REQ_INSERT && !sat) begin
      fin_sum = new_sum;
      fin_cnt = old_cnt + 16'd1;
    end else begin
      fin_sum = old_sum;
      fin_cnt = old_cnt;
    end
  end
  assign mag = fin_sum[47] ? 48'(-fin_sum) : 48'(fin_sum);

  assign shifted = {rem, dq[31]};
  assign qbit    = (shifted >= {1'b0, cnt});
  assign neg_q   = 32'(-dq);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = {fin_sum, fin_cnt};
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (state == S_MOD && req.req_type == REQ_INSERT && !sat) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[idx];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin <= '0;
      x_step   <= 31'd65536;
      x_count  <= 8'd128;
      y_origin <= '0;
      y_step   <= 31'd65536;
      y_count  <= 8'd128;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_X_ORIGIN: x_origin <= cfg_data;
        REG_X_STEP:   x_step   <= cfg_data[30:0];
        REG_X_COUNT:  x_count  <= cfg_data[7:0];
        REG_Y_ORIGIN: y_origin <= cfg_data;
        REG_Y_STEP:   y_step   <= cfg_data[30:0];
        REG_Y_COUNT:  y_count  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      div_done  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(BIN_TOTAL - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req   <= in_req;
            dx    <= {in_req.coord_x[31], in_req.coord_x} - {x_origin[31], x_origin};
            dy    <= {in_req.coord_y[31], in_req.coord_y} - {y_origin[31], y_origin};
            state <= S_RANGE;
          end
        end
        S_RANGE: begin
          // quotient of 256 or more is past any bin count
          if (dx[32] || dy[32] || x_step == '0 || y_step == '0 ||
              xc_eff == '0 || yc_eff == '0 ||
              {7'b0, dx[31:0]} >= {x_step, 8'b0} ||
              {7'b0, dy[31:0]} >= {y_step, 8'b0}) begin
            status   <= STATUS_RANGE;
            div_done <= 1'b1;
            state    <= S_DIV;
          end else begin
            rx      <= dx[31:0];
            ry      <= dy[31:0];
            divx    <= {x_step, 7'b0};
            divy    <= {y_step, 7'b0};
            bit_cnt <= 3'd7;
            state   <= S_BIN;
          end
        end
        S_BIN: begin
          qx <= {qx[QW-2:0], bx};
          qy <= {qy[QW-2:0], by};
          if (bx) rx <= rx - divx[31:0];
          if (by) ry <= ry - divy[31:0];
          divx    <= divx >> 1;
          divy    <= divy >> 1;
          bit_cnt <= bit_cnt - 3'd1;
          if (bit_cnt == 3'd0) begin
            state <= S_INDEX;
          end
        end
        S_INDEX: begin
          if (qx >= xc_eff || qy >= yc_eff) begin
            status   <= STATUS_RANGE;
            div_done <= 1'b1;
            state    <= S_DIV;
          end else begin
            idx   <= ADDR_W'(qx) + ADDR_W'(qy) * ADDR_W'(xc_eff);
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_MOD;
        end
        S_MOD: begin
          status  <= sat ? STATUS_SAT : STATUS_OK;
          cnt     <= fin_cnt;
          neg     <= fin_sum[47];
          rem     <= mag[47:32];
          div_cnt <= 5'd31;
          // empty bin: mean stays zero
          div_done <= (fin_cnt == '0);
          dq       <= (fin_cnt == '0) ? '0 : mag[31:0];
          state <= S_DIV;
        end
        S_DIV: begin
          if (!div_done) begin
            rem <= qbit ? 16'(shifted - {1'b0, cnt}) : shifted[15:0];
            dq  <= {dq[30:0], qbit};
            div_cnt <= div_cnt - 5'd1;
            if (div_cnt == 5'd0) begin
              div_done <= 1'b1;
            end
          end else if (out_load) begin
            if (status == STATUS_RANGE) begin
              out_rsp <= '{status: STATUS_RANGE, bin_index: '0, hit_count: '0,
                           mean_value: '0};
            end else begin
              out_rsp <= '{status: status, bin_index: 14'(idx), hit_count: cnt,
                           mean_value: neg ? neg_q : dq};
            end
            div_done <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### hw/rtl/bma2d_checker.sv
// Port-level checker for the 2D binned mean accumulator, with its bind.
// Depends on bma2d_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bma2d_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input bma2d_pkg::rsp_t out_rsp
);
  import bma2d_pkg::*;

  logic range_ok;
  logic fields_zero;

  assign range_ok    = out_valid && out_rsp.status == STATUS_RANGE;
  assign fields_zero = out_rsp.bin_index == '0 && out_rsp.hit_count == '0 &&
                       out_rsp.mean_value == '0;

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_rsp))
  `ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, rst, !out_valid && in_stall)
  `ASSERT_IMPLY(a_range_zero, clk, rst, range_ok, fields_zero)
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && !in_stall, in_stall)
endmodule

bind binned_mean_accumulator_2d_unit bma2d_checker u_bma2d_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_rsp   (out_rsp)
);
